/* design/swm_pkg.sv */
// ----------------------------------------------------------------------------
// Sliding window median package
// Operation codes and the operation record handed along the row of count cells.
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int MAX_SAMPLE_BITS = 20;
   localparam int MAX_CNT_BITS    = 17;
   localparam int SUM_BITS        = 48;

   typedef enum logic [1:0] {
      OP_INC  = 2'd0,
      OP_DEC  = 2'd1,
      OP_RANK = 2'd2
   } op_kind_type;

   typedef struct packed {
      logic                       valid;
      op_kind_type                kind;
      logic [MAX_SAMPLE_BITS-1:0] value;
      logic [MAX_CNT_BITS-1:0]    kth;
   } op_type;

endpackage

/* design/swm_cell.sv */
// ----------------------------------------------------------------------------
// Count cell
// Holds the occurrence counts of one level of the value tree and performs one
// step of an increment, a decrement or a rank descent on each passing
// operation.
// ----------------------------------------------------------------------------
module swm_cell #(
   parameter int LEVEL       = 0,
   parameter int SAMPLE_BITS = 16,
   parameter int CNT_W       = 13
) (
   input  logic                   clock,
   input  logic                   reset,
   input  swm_pkg::op_type        op_in,
   output swm_pkg::op_type        op_out,
   input  logic                   clr_en,
   input  logic [SAMPLE_BITS-1:0] clr_addr
);

   localparam int AW      = LEVEL + 1;
   localparam int DEPTH   = 1 << AW;
   localparam int BIT_POS = SAMPLE_BITS - 1 - LEVEL;

   logic [CNT_W-1:0]       mem [DEPTH];
   logic [SAMPLE_BITS-1:0] in_value;
   logic [AW-1:0]          rd_addr;
   logic [AW-1:0]          addr_a_ff;
   logic [CNT_W-1:0]       rd_data_ff;
   swm_pkg::op_type        op_a_ff;
   swm_pkg::op_type        op_out_ff;
   swm_pkg::op_type        op_out_in;
   logic [CNT_W-1:0]       kth_a;
   logic                   go_right;
   logic                   wr_en;
   logic [CNT_W-1:0]       wr_data;

   assign in_value = op_in.value[SAMPLE_BITS-1:0];
   assign rd_addr  = AW'(in_value >> BIT_POS);

   always_ff @(posedge clock) begin
      if (op_in.valid) begin
         rd_data_ff <= mem[rd_addr];
      end
      addr_a_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_a_ff   <= '0;
         op_out_ff <= '0;
      end else begin
         op_a_ff   <= op_in;
         op_out_ff <= op_out_in;
      end
   end

   assign kth_a    = op_a_ff.kth[CNT_W-1:0];
   assign go_right = kth_a > rd_data_ff;

   always_comb begin
      wr_en     = 1'b0;
      wr_data   = rd_data_ff;
      op_out_in = op_a_ff;
      unique case (op_a_ff.kind)
         swm_pkg::OP_INC: begin
            wr_en   = op_a_ff.valid;
            wr_data = CNT_W'(rd_data_ff + 1'b1);
         end
         swm_pkg::OP_DEC: begin
            wr_en   = op_a_ff.valid;
            wr_data = CNT_W'(rd_data_ff - 1'b1);
         end
         swm_pkg::OP_RANK: begin
            if (go_right) begin
               op_out_in.value[BIT_POS] = 1'b1;
               op_out_in.kth = swm_pkg::MAX_CNT_BITS'(kth_a - rd_data_ff);
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (clr_en) begin
         mem[clr_addr[AW-1:0]] <= '0;
      end else if (wr_en) begin
         mem[addr_a_ff] <= wr_data;
      end
   end

   assign op_out = op_out_ff;

endmodule

/* design/sliding_window_median_top.sv */
// ----------------------------------------------------------------------------
// Sliding window median filter
// Keeps the most recent samples in a window memory and their value counts in a
// row of count cells, one per tree level, and returns the lower median and a
// saturating running sum of medians once the window is full.
//
// Channel  Direction  Contents
// req      in         tdata: sample
// rsp      out        tdata: median, median_sum
// csr      in         window length, written with csr_write_en
//
// A sample that completes a window runs three operations through the cell row
// (increment, rank, decrement); one that does not runs only the increment.
// After reset and after every window length write the count memories are
// cleared, and req_tready is low while they are being cleared.
// A result waiting on rsp does not stop the next sample from being taken, but
// the result of that sample is held back until the earlier one has left.
// ----------------------------------------------------------------------------
module sliding_window_median_top #(
   parameter int SAMPLE_BITS = 16,
   parameter int WINDOW_MAX  = 4096
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            req_tvalid,
   output logic                                            req_tready,
   // sample
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]                req_tdata,
   output logic                                            rsp_tvalid,
   input  logic                                            rsp_tready,
   // median, median_sum
   output logic [((SAMPLE_BITS+swm_pkg::SUM_BITS+7)/8)*8-1:0] rsp_tdata,
   input  logic                                            csr_write_en,
   input  logic [12:0]                                     csr_write_data
);

   localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
   localparam int PTR_W  = $clog2(WINDOW_MAX);
   localparam int RSP_W  = ((SAMPLE_BITS + swm_pkg::SUM_BITS + 7) / 8) * 8;
   localparam int SUM_W  = swm_pkg::SUM_BITS;
   localparam logic [2:0] SLOT_FIRST = 3'd1;
   localparam logic [2:0] SLOT_RANK  = 3'd2;
   localparam logic [2:0] SLOT_DEC   = 3'd4;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_RUN   = 4'b0100,
      S_EMIT  = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [SAMPLE_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   logic [12:0]            window_len_ff, window_len_in;
   logic [LEN_W-1:0]       fill_ff, fill_in;
   logic [PTR_W-1:0]       oldest_ff, oldest_in;
   logic [2:0]             slot_ff, slot_in;
   logic                   full_ff, full_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   swm_pkg::op_type        op_src_ff, op_src_in;

   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                   bypass_ff, bypass_in;
   logic [SAMPLE_BITS-1:0] median_ff, median_in;
   logic [RSP_W-1:0]       rsp_data_ff, rsp_data_in;
   logic [SAMPLE_BITS-1:0] win_rd_ff;

   logic [SAMPLE_BITS-1:0] win_mem [WINDOW_MAX];

   swm_pkg::op_type        chain [SAMPLE_BITS+1];
   swm_pkg::op_type        chain_out;

   logic                   req_accept;
   logic [SAMPLE_BITS-1:0] sample;
   logic [31:0]            len_ext;
   logic [31:0]            k_full;
   logic [31:0]            kth_full;
   logic [LEN_W-1:0]       k;
   logic                   full_now;
   logic [31:0]            pos_sum;
   logic [31:0]            pos_wrap;
   logic [PTR_W-1:0]       pos;
   logic [31:0]            next_sum;
   logic [31:0]            next_wrap;
   logic [SAMPLE_BITS-1:0] old_sample;
   logic                   op_end;
   logic [SUM_W:0]         sum_add;
   logic [SUM_W-1:0]       sum_sat;
   logic                   clr_en;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign sample     = req_tdata[SAMPLE_BITS-1:0];

   assign len_ext  = 32'(window_len_ff);
   assign k_full   = (len_ext == 32'd0) ? 32'd1 :
                     (len_ext > 32'(WINDOW_MAX)) ? 32'(WINDOW_MAX) : len_ext;
   assign kth_full = (k_full + 32'd1) >> 1;
   assign k        = k_full[LEN_W-1:0];
   assign full_now = (LEN_W'(fill_ff + 1'b1) == k);

   assign pos_sum   = 32'(oldest_ff) + 32'(fill_ff);
   assign pos_wrap  = (pos_sum >= 32'(WINDOW_MAX)) ? pos_sum - 32'(WINDOW_MAX) : pos_sum;
   assign pos       = pos_wrap[PTR_W-1:0];
   assign next_sum  = 32'(oldest_ff) + 32'd1;
   assign next_wrap = (next_sum >= 32'(WINDOW_MAX)) ? next_sum - 32'(WINDOW_MAX) : next_sum;

   assign old_sample = bypass_ff ? sample_ff : win_rd_ff;

   assign sum_add = {1'b0, sum_ff} + (SUM_W+1)'(median_ff);
   assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

   assign chain_out = chain[SAMPLE_BITS];
   assign op_end    = chain_out.valid &&
                      ((full_ff && chain_out.kind == swm_pkg::OP_DEC) ||
                       (!full_ff && chain_out.kind == swm_pkg::OP_INC));

   always_ff @(posedge clock) begin
      if (req_accept) begin
         win_mem[pos] <= sample;
         win_rd_ff    <= win_mem[oldest_ff];
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      window_len_in = window_len_ff;
      fill_in       = fill_ff;
      oldest_in     = oldest_ff;
      slot_in       = slot_ff;
      full_in       = full_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      op_src_in     = '0;
      sample_in     = sample_ff;
      bypass_in     = bypass_ff;
      median_in     = median_ff;
      rsp_data_in   = rsp_data_ff;

      if (chain_out.valid && chain_out.kind == swm_pkg::OP_RANK) begin
         median_in = chain_out.value[SAMPLE_BITS-1:0];
      end

      unique case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = SAMPLE_BITS'(clr_cnt_ff + 1'b1);
            if (clr_cnt_ff == {SAMPLE_BITS{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               sample_in       = sample;
               bypass_in       = (fill_ff == '0);
               full_in         = full_now;
               fill_in         = full_now ? fill_ff : LEN_W'(fill_ff + 1'b1);
               oldest_in       = full_now ? next_wrap[PTR_W-1:0] : oldest_ff;
               slot_in         = SLOT_FIRST;
               op_src_in.valid = 1'b1;
               op_src_in.kind  = swm_pkg::OP_INC;
               op_src_in.value = swm_pkg::MAX_SAMPLE_BITS'(sample);
               state_in        = S_RUN;
            end
         end
         S_RUN: begin
            if (slot_ff == SLOT_DEC) begin
               slot_in = '0;
            end else if (slot_ff != '0) begin
               slot_in = 3'(slot_ff + 1'b1);
            end
            if (full_ff && slot_ff == SLOT_RANK) begin
               op_src_in.valid = 1'b1;
               op_src_in.kind  = swm_pkg::OP_RANK;
               op_src_in.kth   = swm_pkg::MAX_CNT_BITS'(kth_full[LEN_W-1:0]);
            end
            if (full_ff && slot_ff == SLOT_DEC) begin
               op_src_in.valid = 1'b1;
               op_src_in.kind  = swm_pkg::OP_DEC;
               op_src_in.value = swm_pkg::MAX_SAMPLE_BITS'(old_sample);
            end
            if (op_end) begin
               state_in = full_ff ? S_EMIT : S_IDLE;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({sum_sat, median_ff});
               sum_in       = sum_sat;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase

      if (csr_write_en) begin
         window_len_in = csr_write_data;
         fill_in       = '0;
         oldest_in     = '0;
         clr_cnt_in    = '0;
         state_in      = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         window_len_ff <= 13'd3;
         fill_ff       <= '0;
         oldest_ff     <= '0;
         slot_ff       <= '0;
         full_ff       <= 1'b0;
         sum_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         op_src_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         window_len_ff <= window_len_in;
         fill_ff       <= fill_in;
         oldest_ff     <= oldest_in;
         slot_ff       <= slot_in;
         full_ff       <= full_in;
         sum_ff        <= sum_in;
         rsp_valid_ff  <= rsp_valid_in;
         op_src_ff     <= op_src_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      bypass_ff   <= bypass_in;
      median_ff   <= median_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign clr_en   = (state_ff == S_CLEAR);
   assign chain[0] = op_src_ff;

   for (genvar g = 0; g < SAMPLE_BITS; g++) begin : g_cell
      swm_cell #(
         .LEVEL       (g),
         .SAMPLE_BITS (SAMPLE_BITS),
         .CNT_W       (LEN_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .op_in    (chain[g]),
         .op_out   (chain[g+1]),
         .clr_en   (clr_en),
         .clr_addr (clr_cnt_ff)
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Sliding window median filter testbench
// Streams samples into the filter under several window lengths, predicts the
// lower median of each full window and the saturating running sum of medians
// with a value-count tree of its own, and compares every result transfer in
// order. Both channels idle at random, and the result side also holds off for
// a long stretch.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS   = 16;
   localparam int WINDOW_MAX    = 4096;
   localparam int VALUE_COUNT   = 1 << SAMPLE_BITS;
   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int IDLE_PERCENT  = 27;
   localparam int HOLD_CYCLES   = 2000;

   typedef struct packed {
      logic [swm_pkg::SUM_BITS-1:0] median_sum;
      logic [SAMPLE_BITS-1:0]       median;
   } median_result_type;

   logic                         clock;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [15:0]                  req_tdata;   // sample
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [63:0]                  rsp_tdata;   // median, median_sum
   logic                         csr_write_en;
   logic [12:0]                  csr_write_data;

   // Predictor state.
   logic [12:0]                  window_len;
   logic [12:0]                  value_tally [1:2*VALUE_COUNT-1];
   logic [SAMPLE_BITS-1:0]       window_samples [$];
   logic [swm_pkg::SUM_BITS-1:0] median_total;
   median_result_type            pending_medians [$];

   int                           mismatch_count;
   int                           cycle_count;
   int                           hold_left;
   bit                           tx_calm;
   bit                           rx_calm;

   sliding_window_median_top #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .WINDOW_MAX  (WINDOW_MAX)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic int unsigned effective_len();
      if (window_len == 0) return 1;
      if (window_len > WINDOW_MAX) return WINDOW_MAX;
      return 32'(window_len);
   endfunction

   function automatic void clear_tally();
      window_samples.delete();
      for (int n = 1; n < 2 * VALUE_COUNT; n++) value_tally[n] = '0;
   endfunction

   function automatic void adjust_tally(input logic [SAMPLE_BITS-1:0] value, input bit up);
      int unsigned node;
      node = VALUE_COUNT + value;
      while (node >= 1) begin
         value_tally[node] = up ? value_tally[node] + 1'b1 : value_tally[node] - 1'b1;
         node = node >> 1;
      end
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] select_rank(input int unsigned kth);
      int unsigned node;
      node = 1;
      while (node < VALUE_COUNT) begin
         if (kth <= value_tally[2*node]) begin
            node = 2 * node;
         end else begin
            kth = kth - value_tally[2*node];
            node = 2 * node + 1;
         end
      end
      return SAMPLE_BITS'(node - VALUE_COUNT);
   endfunction

   function automatic void advance_median_window(input logic [SAMPLE_BITS-1:0] sample);
      int unsigned                k;
      logic [swm_pkg::SUM_BITS:0] total;
      median_result_type          result;
      logic [SAMPLE_BITS-1:0]     oldest;
      k = effective_len();
      window_samples.insert(window_samples.size(), sample);
      adjust_tally(sample, 1'b1);
      if (window_samples.size() == k) begin
         result.median = select_rank((k + 1) / 2);
         total = {1'b0, median_total} + result.median;
         median_total = total[swm_pkg::SUM_BITS] ? '1 : total[swm_pkg::SUM_BITS-1:0];
         result.median_sum = median_total;
         pending_medians.insert(pending_medians.size(), result);
         oldest = window_samples[0];
         window_samples.delete(0);
         adjust_tally(oldest, 1'b0);
      end
   endfunction

   function automatic bit take_gap(input bit calm);
      return !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic [SAMPLE_BITS-1:0] centre);
      logic [SAMPLE_BITS-1:0] value;
      case ($urandom_range(0, 5))
         0, 1: value = SAMPLE_BITS'($urandom);
         2, 3: value = SAMPLE_BITS'(centre + $urandom_range(0, 7));
         4: value = $urandom_range(0, 1) ? '1 : '0;
         default: value = SAMPLE_BITS'(1) << $urandom_range(0, SAMPLE_BITS - 1);
      endcase
      return value;
   endfunction

   // Returns at the rising edge at which the transfer took place.
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] sample);
      @(negedge clock);
      while (take_gap(tx_calm)) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      do @(posedge clock); while (!req_tready);
      advance_median_window(sample);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_medians.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_window_len(input logic [12:0] len);
      wait_for_results();
      csr_write_en   <= 1'b1;
      csr_write_data <= len;
      window_len = len;
      clear_tally();
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_phase(input logic [12:0] len, input int count);
      logic [SAMPLE_BITS-1:0] centre;
      write_window_len(len);
      centre = SAMPLE_BITS'($urandom);
      repeat (count) send_sample(pick_sample(centre));
   endtask

   task automatic test_default_window();
      logic [SAMPLE_BITS-1:0] picks [$] = '{
         16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE,
         16'h0005, 16'h0005, 16'h0005, 16'h0001, 16'h0002, 16'h0003,
         16'h0003, 16'h0002, 16'h0001, 16'hFFFF, 16'hFFFF, 16'h0000,
         16'hAAAA, 16'h5555
      };
      foreach (picks[i]) send_sample(picks[i]);
   endtask

   task automatic test_unit_window();
      logic [SAMPLE_BITS-1:0] picks [$] = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h8000};
      write_window_len(13'd0);
      foreach (picks[i]) send_sample(picks[i]);
      run_phase(13'd1, 20);
   endtask

   task automatic test_backpressure();
      hold_left = HOLD_CYCLES;
      repeat (120) send_sample(SAMPLE_BITS'($urandom));
      wait_for_results();
   endtask

   task automatic test_random_windows();
      tx_calm = 1'b1;
      rx_calm = 1'b1;
      run_phase(13'd2, 200);
      tx_calm = 1'b0;
      rx_calm = 1'b0;
      run_phase(13'($urandom_range(3, 17)), 300);
      run_phase(13'($urandom_range(18, 300)), 350);
   endtask

   task automatic test_longest_window();
      run_phase(13'h1FFF, 100);
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left = hold_left - 1;
         end else begin
            rsp_tready <= !take_gap(rx_calm);
         end
      end
   end

   always @(posedge clock) begin
      median_result_type exp_result;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_medians.size() == 0) begin
            $error("unexpected result transfer: median %0d, median_sum %0d",
                   rsp_tdata[15:0], rsp_tdata[63:16]);
            mismatch_count++;
         end else begin
            exp_result = pending_medians[0];
            pending_medians.delete(0);
            if (rsp_tdata[15:0] !== exp_result.median) begin
               $error("median: expected %0d, actual %0d", exp_result.median, rsp_tdata[15:0]);
               mismatch_count++;
            end
            if (rsp_tdata[63:16] !== exp_result.median_sum) begin
               $error("median_sum: expected %0d, actual %0d",
                      exp_result.median_sum, rsp_tdata[63:16]);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      mismatch_count = 0;
      cycle_count    = 0;
      hold_left      = 0;
      tx_calm        = 1'b0;
      rx_calm        = 1'b0;
      window_len     = 13'd3;
      median_total   = '0;
      clear_tally();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_window();
      test_unit_window();
      test_backpressure();
      test_random_windows();
      test_longest_window();
      wait_for_results();

      if (mismatch_count == 0 && pending_medians.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
